FILE: hdl/dmpc_pkg.sv
// dmpc_pkg: constants, item type and per-byte update functions shared by the
// payload checksum block. No dependencies.

package dmpc_pkg;

	localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_XOR_OUT      = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY_REFL    = 32'h82F6_3B78;

	localparam logic ALG_FNV1A64 = 1'b0;
	localparam logic ALG_CRC32C  = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_byte;
	} dmpc_item_t;

	// starting state for a payload
	function automatic logic [63:0] init_value(input logic alg);
		logic [63:0] v;
		begin
			if (alg == ALG_CRC32C) begin
				v = {32'h0, CRC_INIT};
			end else begin
				v = FNV_OFFSET_BASIS;
			end
			return v;
		end
	endfunction

	// one byte through reflected CRC-32C, LSB first
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		begin
			c = crc ^ {24'h0, b};
			for (int k = 0; k < 8; k++) begin
				c = (c >> 1) ^ (c[0] ? CRC_POLY_REFL : 32'h0);
			end
			return c;
		end
	endfunction

	// FNV-1a 64 step; prime 0x100000001B3 = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
	function automatic logic [63:0] fnv1a_byte(input logic [63:0] st, input logic [7:0] b);
		logic [63:0] t;
		begin
			t = st ^ {56'h0, b};
			return (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
		end
	endfunction

endpackage

FILE: hdl/dmpc_absorb.sv
// dmpc_absorb: datapath for one request - folds the byte into the running
// state and forms the finished checksum. Depends on dmpc_pkg.

module dmpc_absorb import dmpc_pkg::*; (
	input  logic       alg,
	input  logic [63:0] sum,
	input  dmpc_item_t item,
	output logic [63:0] next_sum,
	output logic [63:0] checksum
);

	logic [63:0] absorbed;

	always_comb begin
		if (alg == ALG_CRC32C) begin
			absorbed = {32'h0, crc32c_byte(sum[31:0], item.data_byte)};
		end else begin
			absorbed = fnv1a_byte(sum, item.data_byte);
		end
	end

	assign next_sum = item.has_byte ? absorbed : sum;

	always_comb begin
		if (alg == ALG_CRC32C) begin
			checksum = {32'h0, next_sum[31:0] ^ CRC_XOR_OUT};
		end else begin
			checksum = next_sum;
		end
	end

endmodule

FILE: hdl/dual_mode_payload_checksum.sv
// dual_mode_payload_checksum: payload checksum over a byte stream, FNV-1a 64
// or CRC-32C. Depends on dmpc_pkg and dmpc_absorb.
//
// Usage:
//   Input channel (in_valid/in_stall): one request per payload byte with
//   data_byte, has_byte and last_byte. has_byte=0 with last_byte=1 closes an
//   empty payload; has_byte=0 with last_byte=0 is a no-op.
//   Output channel (out_valid/out_stall): one checksum_value per request
//   marked last_byte. CRC-32C results sit in bits 31..0, upper bits zero.
//   cfg_we/cfg_wdata write algorithm_select (0 FNV-1a 64, 1 CRC-32C) and
//   restart the running state; write only while the block is idle.
// Timing:
//   A request is registered at acceptance and then folded into the running
//   state, where a last request loads the output register that offers its
//   result. One request per cycle sustained while in_stall stays low; the
//   state update is a combinational shift-add or 8-step CRC.
// Reset: selects FNV-1a 64, state at the offset basis, both stages empty.
// Stall: the output register holds; a pending last request waits in the
//   input register and in_stall rises until the result is taken.

module dual_mode_payload_checksum import dmpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] checksum_value
);

	logic        alg_q;
	logic [63:0] sum_q;
	logic        valid_s1;
	dmpc_item_t  item_s1;
	logic        out_valid_q;
	logic [63:0] checksum_q;
	logic [63:0] next_sum;
	logic [63:0] checksum;
	logic        advance;
	logic        fire;

	dmpc_absorb u_absorb (
		.alg      (alg_q),
		.sum      (sum_q),
		.item     (item_s1),
		.next_sum (next_sum),
		.checksum (checksum)
	);

	// a last request can only retire into a free (or draining) output register
	assign advance  = !(item_s1.last_byte && out_valid_q && out_stall);
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= '{data_byte: data_byte, has_byte: has_byte, last_byte: last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q <= ALG_FNV1A64;
			sum_q <= FNV_OFFSET_BASIS;
		end else if (cfg_we) begin
			alg_q <= cfg_wdata;
			sum_q <= init_value(cfg_wdata);
		end else if (fire) begin
			if (item_s1.last_byte) begin
				sum_q <= init_value(alg_q);
			end else begin
				sum_q <= next_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item_s1.last_byte) begin
			checksum_q <= checksum;
		end
	end

	assign out_valid      = out_valid_q;
	assign checksum_value = checksum_q;

`ifndef NO_ASSERTIONS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && item_s1.last_byte && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.last_byte && !in_stall) |=> out_valid)
		else $error("retired last request produced no result");

	a_crc_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(alg_q == ALG_CRC32C) |-> (sum_q[63:32] == 32'h0))
		else $error("CRC state has upper bits set");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.last_byte && !cfg_we) |=> (sum_q == init_value(alg_q)))
		else $error("state not restarted after last request");
`endif

endmodule
